// ===== hw/rtl/spm_pkg.sv =====
package spm_pkg;

  // Datapath widths
  localparam int ACCEL_BITS = 16;          // used low bits of each axis, 8..16
  localparam int TIME_BITS  = 32;          // used low bits of the timestamp, 16..32
  localparam int AXIS_W     = 16;
  localparam int SUM_W      = 2 * AXIS_W;  // sum of three squares fits below 2^32
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 1;
  localparam int G_W        = 16;
  localparam int CFG_TIME_W = 32;
  localparam int CNT_W      = 4;
  localparam int AXES       = 3;

  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(AXES - 1);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);

  // Register indexes on the configuration port
  localparam logic [2:0] REG_SHOCK_THR  = 3'd0;
  localparam logic [2:0] REG_MOTION_HI  = 3'd1;
  localparam logic [2:0] REG_MOTION_LO  = 3'd2;
  localparam logic [2:0] REG_IDLE_G     = 3'd3;
  localparam logic [2:0] REG_DEAD_TIME  = 3'd4;
  localparam logic [2:0] REG_REPORT_INT = 3'd5;

  // Register reset values
  localparam logic [G_W-1:0]        RST_SHOCK_THR  = 16'd7373;
  localparam logic [G_W-1:0]        RST_MOTION_HI  = 16'd5325;
  localparam logic [G_W-1:0]        RST_MOTION_LO  = 16'd2867;
  localparam logic [G_W-1:0]        RST_IDLE_G     = 16'd4096;
  localparam logic [CFG_TIME_W-1:0] RST_DEAD_TIME  = 32'd3000;
  localparam logic [CFG_TIME_W-1:0] RST_REPORT_INT = 32'd60000;

  // Input command and report codes
  localparam logic CMD_SAMPLE     = 1'b0;
  localparam logic CMD_TIME_CHECK = 1'b1;
  localparam logic KIND_SHOCK     = 1'b0;
  localparam logic KIND_PERIODIC  = 1'b1;

  localparam logic [1:0] STAT_SAFE   = 2'd0;
  localparam logic [1:0] STAT_MOVING = 2'd1;
  localparam logic [1:0] STAT_IMPACT = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SQR    = 6'b000010,
    S_ROOT   = 6'b000100,
    S_UPD    = 6'b001000,
    S_SHOCK  = 6'b010000,
    S_PERIOD = 6'b100000
  } state_t;

  typedef struct packed {
    logic [G_W-1:0]        shock_thr;
    logic [G_W-1:0]        motion_hi;
    logic [G_W-1:0]        motion_lo;
    logic [G_W-1:0]        idle_g;
    logic [CFG_TIME_W-1:0] dead_time;
    logic [CFG_TIME_W-1:0] report_int;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             sq_step;
    logic [1:0]       axis_sel;
    logic             root_step;
    logic             upd;
    logic             emit_shock;
    logic             emit_period;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic shock_hit;
    logic due;
  } dp_sts_t;

endpackage

// ===== hw/rtl/spm_ctrl.sv =====
module spm_ctrl
  import spm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_cmd,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.axis_sel = cnt_r[1:0];
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = (in_cmd == CMD_TIME_CHECK) ? S_UPD : S_SQR;
        end
      end
      S_SQR: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == ROOT_LAST) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_SHOCK;
      end
      S_SHOCK: begin
        if (!sts.shock_hit) begin
          state_nxt = S_PERIOD;
        end else if (sts.slot_free) begin
          cmd.emit_shock = 1'b1;
          state_nxt      = S_PERIOD;
        end
      end
      S_PERIOD: begin
        if (!sts.due) begin
          state_nxt = S_IDLE;
        end else if (sts.slot_free) begin
          cmd.emit_period = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/spm_dp.sv =====
module spm_dp
  import spm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  in_cmd,
  input  logic [31:0]           in_now,
  input  logic [AXIS_W-1:0]     in_ax,
  input  logic [AXIS_W-1:0]     in_ay,
  input  logic [AXIS_W-1:0]     in_az,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_kind,
  output logic [G_W-1:0]        out_g,
  output logic [1:0]            out_status,
  output logic                  out_last
);

  logic                        cmd_r;
  logic [TIME_BITS-1:0]        now_r;
  logic signed [AXIS_W-1:0]    ax_r [AXES];
  logic [SUM_W-1:0]            acc_r;
  logic [REM_W-1:0]            rem_r;
  logic [ROOT_W-1:0]           root_r;
  logic [G_W-1:0]              peak_r;
  logic [TIME_BITS-1:0]        last_shock_r;
  logic [TIME_BITS-1:0]        last_report_r;
  logic                        shock_hit_r;
  logic                        due_r;
  logic                        out_valid_r;
  logic                        out_kind_r;
  logic [G_W-1:0]              out_g_r;
  logic [1:0]                  out_status_r;
  logic                        out_last_r;

  logic signed [AXIS_W-1:0]    ax_sel;
  logic signed [SUM_W-1:0]     sq;
  logic [REM_W+1:0]            rem_sh;
  logic [REM_W+1:0]            trial;
  logic [TIME_BITS-1:0]        shock_gap;
  logic [TIME_BITS-1:0]        report_gap;
  logic [G_W-1:0]              mag;
  logic [1:0]                  period_status;

  // Keep the low ACCEL_BITS of an axis, sign-extended
  function automatic logic signed [AXIS_W-1:0] axis_ext(input logic [AXIS_W-1:0] raw);
    logic signed [ACCEL_BITS-1:0] low;
    low = signed'(raw[ACCEL_BITS-1:0]);
    return AXIS_W'(low);
  endfunction

  always_comb begin
    case (cmd.axis_sel)
      2'd0:    ax_sel = ax_r[0];
      2'd1:    ax_sel = ax_r[1];
      2'd2:    ax_sel = ax_r[2];
      default: ax_sel = '0;
    endcase
  end

  assign sq     = ax_sel * ax_sel;
  assign rem_sh = {rem_r, acc_r[SUM_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});
  assign mag    = G_W'(root_r);

  assign shock_gap  = now_r - last_shock_r;
  assign report_gap = now_r - last_report_r;

  always_comb begin
    if (peak_r > cfg.shock_thr) begin
      period_status = STAT_IMPACT;
    end else if (peak_r > cfg.motion_hi || peak_r < cfg.motion_lo) begin
      period_status = STAT_MOVING;
    end else begin
      period_status = STAT_SAFE;
    end
  end

  // Item registers and square-root iteration
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      now_r   <= in_now[TIME_BITS-1:0];
      ax_r[0] <= axis_ext(in_ax);
      ax_r[1] <= axis_ext(in_ay);
      ax_r[2] <= axis_ext(in_az);
      acc_r   <= '0;
      rem_r   <= '0;
      root_r  <= '0;
    end else if (cmd.sq_step) begin
      acc_r <= acc_r + SUM_W'(unsigned'(sq));
    end else if (cmd.root_step) begin
      acc_r <= {acc_r[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= REM_W'(rem_sh - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= REM_W'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Monitor state: peak, last shock and last report times
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r        <= RST_IDLE_G;
      last_shock_r  <= '0;
      last_report_r <= '0;
      shock_hit_r   <= 1'b0;
      due_r         <= 1'b0;
    end else begin
      if (cmd.upd) begin
        if (cmd_r == CMD_SAMPLE && mag > peak_r) begin
          peak_r <= mag;
        end
        shock_hit_r <= (cmd_r == CMD_SAMPLE) && (mag >= cfg.shock_thr) &&
                       (CFG_TIME_W'(shock_gap) >= cfg.dead_time);
        due_r       <= CFG_TIME_W'(report_gap) >= cfg.report_int;
      end
      if (cmd.emit_shock) begin
        last_shock_r <= now_r;
        peak_r       <= cfg.idle_g;
      end
      if (cmd.emit_period) begin
        last_report_r <= now_r;
        peak_r        <= cfg.idle_g;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_shock || cmd.emit_period) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_shock) begin
      out_kind_r   <= KIND_SHOCK;
      out_g_r      <= mag;
      out_status_r <= STAT_IMPACT;
      out_last_r   <= !due_r;
    end else if (cmd.emit_period) begin
      out_kind_r   <= KIND_PERIODIC;
      out_g_r      <= peak_r;
      out_status_r <= period_status;
      out_last_r   <= 1'b1;
    end
  end

  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.shock_hit  = shock_hit_r;
  assign sts.due        = due_r;

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_g      = out_g_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// ===== hw/rtl/shock_peak_monitor.sv =====
// Shock peak monitor: tracks acceleration magnitude and issues shock and
// periodic reports.
// Input channel (in_*): one item per sample or time check. in_tuser selects
// a sample (0) or a time check (1); in_tdata carries the timestamp and axes.
// Result channel (out_*): zero, one or two report items per input item;
// out_tlast marks the final report of an item, out_tuser the report kind.
// Configuration (cfg_*): APB-style, six registers at byte addresses 0..20,
// to be written by the user only while the block is idle; the block itself
// does not enforce this. Reads return the register value. A sample's shock
// report is loaded after squaring the three axes with one multiplier, 16
// iterations of a bit-serial square root and a peak update, in the shock
// slot; a periodic report is loaded in the periodic slot that follows. A
// time check goes straight to the peak update and the two report slots.
// The block takes one item at a time and accepts the next once its reports
// are loaded into the output register.
// Reset (synchronous, rst_n low): registers return to their defaults, peak
// to one g, shock and report timestamps to zero, output register empties.
// A stalled receiver holds the output register; the block waits before
// loading another report and takes no new item until then.
module shock_peak_monitor
  import spm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: now_ms[31:0], accel_x[47:32], accel_y[63:48], accel_z[79:64]
  input  logic [79:0] in_tdata,
  // in_tuser: command[0]
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: g_value[15:0], status[17:16], zero fill [23:18]
  output logic [23:0] out_tdata,
  // out_tuser: report_kind[0]
  output logic        out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t       cfg_r;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic [G_W-1:0] out_g;
  logic [1:0] out_status;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shock_thr  <= RST_SHOCK_THR;
      cfg_r.motion_hi  <= RST_MOTION_HI;
      cfg_r.motion_lo  <= RST_MOTION_LO;
      cfg_r.idle_g     <= RST_IDLE_G;
      cfg_r.dead_time  <= RST_DEAD_TIME;
      cfg_r.report_int <= RST_REPORT_INT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SHOCK_THR:  cfg_r.shock_thr  <= cfg_pwdata[G_W-1:0];
        REG_MOTION_HI:  cfg_r.motion_hi  <= cfg_pwdata[G_W-1:0];
        REG_MOTION_LO:  cfg_r.motion_lo  <= cfg_pwdata[G_W-1:0];
        REG_IDLE_G:     cfg_r.idle_g     <= cfg_pwdata[G_W-1:0];
        REG_DEAD_TIME:  cfg_r.dead_time  <= cfg_pwdata;
        REG_REPORT_INT: cfg_r.report_int <= cfg_pwdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SHOCK_THR:  cfg_prdata = 32'(cfg_r.shock_thr);
      REG_MOTION_HI:  cfg_prdata = 32'(cfg_r.motion_hi);
      REG_MOTION_LO:  cfg_prdata = 32'(cfg_r.motion_lo);
      REG_IDLE_G:     cfg_prdata = 32'(cfg_r.idle_g);
      REG_DEAD_TIME:  cfg_prdata = cfg_r.dead_time;
      REG_REPORT_INT: cfg_prdata = cfg_r.report_int;
      default:        cfg_prdata = '0;
    endcase
  end

  // Sequencer: accept, square, root, update, report
  spm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Magnitude, peak tracking, timers and output register
  spm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .sts        (sts),
    .in_cmd     (in_tuser),
    .in_now     (in_tdata[31:0]),
    .in_ax      (in_tdata[47:32]),
    .in_ay      (in_tdata[63:48]),
    .in_az      (in_tdata[79:64]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_kind   (out_tuser),
    .out_g      (out_g),
    .out_status (out_status),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'b0, out_status, out_g};

endmodule
